[rtl/core/fmv_pkg.sv]
// Package with the types, constants and table builders of the FM voice.
`timescale 1ns / 1ps
package fmv_pkg;

    localparam int TABLE_SIZE          = 4096;
    localparam int MAX_HARMONICS       = 64;
    localparam int PHASE_FRACTION_BITS = 16;

    localparam int TBL_BITS    = $clog2(TABLE_SIZE);
    localparam int TBL_QUARTER = TABLE_SIZE / 4;
    localparam int TBL_HALF    = TABLE_SIZE / 2;
    localparam int PH_W        = TBL_BITS + PHASE_FRACTION_BITS;
    localparam int QDEPTH      = TABLE_SIZE / 4 + 1;
    localparam int QIDX_W      = TBL_BITS - 1;
    localparam int K_W         = $clog2(MAX_HARMONICS + 3);
    localparam int RDEPTH      = 2 ** K_W;
    localparam int ENV_DEPTH   = 4096;
    localparam int ENV_AW      = 12;
    localparam int OFF_SH      = TBL_BITS - (24 - PHASE_FRACTION_BITS);
    localparam int OFF_LSH     = (OFF_SH > 0) ? OFF_SH : 0;
    localparam int OFF_RSH     = (OFF_SH < 0) ? -OFF_SH : 0;

    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [16:0] SAW_GAIN_Q16   = 17'd41722;
    localparam logic [16:0] SQ_GAIN_Q16    = 17'd83443;

    localparam logic [1:0] FORM_SINE   = 2'd0;
    localparam logic [1:0] FORM_SAW    = 2'd1;
    localparam logic [1:0] FORM_SQUARE = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [2:0] CFG_FORM    = 3'd0;
    localparam logic [2:0] CFG_AMP     = 3'd1;
    localparam logic [2:0] CFG_CPITCH  = 3'd2;
    localparam logic [2:0] CFG_MPITCH  = 3'd3;
    localparam logic [2:0] CFG_INDEX   = 3'd4;
    localparam logic [2:0] CFG_HCOUNT  = 3'd5;

    typedef struct packed {
        logic               cmd;
        logic [11:0]        env_addr;
        logic signed [15:0] env_value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               clipped;
    } t_out_item;

    typedef struct packed {
        logic env_wr;
        logic rd_mod;
        logic mul1;
        logic mul2;
        logic off1;
        logic off2;
        logic rd_car;
        logic sine_cap;
        logic harm_init;
        logic harm_issue;
        logic gain;
        logic s_zero;
        logic scale;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] form;
        logic       harm_done;
        logic       pipe_busy;
        logic       out_busy;
    } t_sts;

    typedef logic [QDEPTH-1:0][14:0] t_qrom;
    typedef logic [RDEPTH-1:0][31:0] t_recip;

    // Shift and subtract quotient, used only while the constant tables are built.
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [14:0] quarter_sine(input int unsigned j);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint unsigned div;
        longint unsigned res;
        x    = (longint'(j) * 64'd6746518852) >> TBL_BITS;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            div  = longint'((2 * n) * (2 * n + 1));
            term = udiv(term, div);
            if ((n & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        res = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
        return res[14:0];
    endfunction

    function automatic t_qrom build_qrom();
        t_qrom q;
        for (int i = 0; i < QDEPTH; i++) begin
            q[i] = quarter_sine(i);
        end
        return q;
    endfunction

    function automatic t_recip build_recip();
        t_recip r;
        longint unsigned v;
        for (int k = 0; k < RDEPTH; k++) begin
            if (k == 0) begin
                r[k] = 32'd0;
            end else begin
                v    = udiv((64'd1 << 31) + 64'(k) - 64'd1, 64'(k));
                r[k] = v[31:0];
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/fm_voice_oscillator_top.sv]
// Top level of the two-operator FM voice with configuration port.
// A write item is done in the idle state; a tick item runs the controller states,
// and for saw or square the harmonic loop reads H harmonics, where H is the
// harmonic count (ceil(H/2) for square), through the single sine ROM read port
// that the loop shares. One item is in work at a time; the result register
// frees the controller. Reset sets the settings to their defaults and clears
// phases and envelope position; the envelope memory holds no value until written.
`timescale 1ns / 1ps
module fm_voice_oscillator_top import fmv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [27:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    fmv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in.cmd),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    fmv_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.cmd == CMD_TICK) |=> !o_in_ready)
        else $error("tick item did not hold off the input channel");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.cmd == CMD_WRITE && !o_out_valid)
        |=> !o_out_valid)
        else $error("write item produced a result");

    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.clipped) |->
        (o_out.sample_out == 16'sh7fff || o_out.sample_out == 16'sh8000))
        else $error("clipped item is not at a rail");

endmodule

[rtl/core/fmv_ctrl.sv]
// Controller state machine that sequences one item through the voice datapath.
`timescale 1ns / 1ps
module fmv_ctrl import fmv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_cmd,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RD    = 13'b0000000000010,
        S_MUL1  = 13'b0000000000100,
        S_MUL2  = 13'b0000000001000,
        S_OFF1  = 13'b0000000010000,
        S_OFF2  = 13'b0000000100000,
        S_FORM  = 13'b0000001000000,
        S_SINE  = 13'b0000010000000,
        S_HARM  = 13'b0000100000000,
        S_DRAIN = 13'b0001000000000,
        S_GAIN  = 13'b0010000000000,
        S_SCALE = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_cmd == CMD_TICK) begin
                        n_state = S_RD;
                    end else begin
                        o_cmd.env_wr = 1'b1;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_mod = 1'b1;
                n_state      = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_OFF1;
            end
            S_OFF1: begin
                o_cmd.off1 = 1'b1;
                n_state    = S_OFF2;
            end
            S_OFF2: begin
                o_cmd.off2 = 1'b1;
                n_state    = S_FORM;
            end
            S_FORM: begin
                case (i_sts.form) inside
                    FORM_SINE: begin
                        o_cmd.rd_car = 1'b1;
                        n_state      = S_SINE;
                    end
                    FORM_SAW, FORM_SQUARE: begin
                        o_cmd.harm_init = 1'b1;
                        n_state         = S_HARM;
                    end
                    default: begin
                        o_cmd.s_zero = 1'b1;
                        n_state      = S_SCALE;
                    end
                endcase
            end
            S_SINE: begin
                o_cmd.sine_cap = 1'b1;
                n_state        = S_SCALE;
            end
            S_HARM: begin
                if (i_sts.harm_done) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.harm_issue = 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_GAIN;
                end
            end
            S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/fmv_dp.sv]
// Datapath of the FM voice: settings, phases, envelope memory, sine ROM and arithmetic.
`timescale 1ns / 1ps
module fmv_dp import fmv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  t_in_item  i_in,
    input  logic      i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [27:0] i_cfg_data,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out
);

    localparam t_qrom   SINE_Q = build_qrom();
    localparam t_recip  RECIP  = build_recip();

    logic [1:0]  r_form;
    logic [15:0] r_amp;
    logic [27:0] r_cpitch;
    logic [27:0] r_mpitch;
    logic [15:0] r_index;
    logic [6:0]  r_hcount;

    logic [PH_W-1:0]   r_cp;
    logic [PH_W-1:0]   r_mp;
    logic [ENV_AW-1:0] r_pos;

    logic signed [15:0] r_env_mem [ENV_DEPTH];
    logic signed [15:0] r_env_q;

    logic [PH_W-1:0]     ph_sel;
    logic [TBL_BITS-1:0] rom_idx;
    logic [TBL_BITS-1:0] rom_ext;
    logic [TBL_BITS-1:0] rom_j;
    logic [QIDX_W-1:0]   qidx;
    logic [14:0]         r_rq;
    logic                r_rneg;
    logic [15:0]         mag16;
    logic signed [15:0]  sine_val;

    logic signed [32:0] r_ei;
    logic signed [15:0] r_m;
    logic signed [48:0] r_p;
    logic [48:0]        pmag;
    logic [57:0]        offprod;
    logic [33:0]        r_offa;
    logic               r_pneg;
    logic [63:0]        off64;
    logic [PH_W-1:0]    offp;
    logic [PH_W-1:0]    r_c;
    logic [PH_W-1:0]    base;

    logic [PH_W-1:0] r_hp;
    logic [PH_W-1:0] r_inc;
    logic [K_W-1:0]  r_k;
    logic [K_W-1:0]  h;
    logic [7:0]      hc8;
    logic            r_v1;
    logic [K_W-1:0]  r_k1;
    logic            r_v2;
    logic [54:0]     r_prod;
    logic            r_pn;
    logic [23:0]     hq;
    logic signed [31:0] r_sum;

    logic [31:0]        smag;
    logic [16:0]        gsel;
    logic [48:0]        gprod;
    logic [24:0]        gq;
    logic signed [25:0] r_s;
    logic [25:0]        amag;
    logic [41:0]        aprod;
    logic [26:0]        aq;
    logic signed [27:0] r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_form   <= FORM_SINE;
            r_amp    <= 16'd32768;
            r_cpitch <= '0;
            r_mpitch <= '0;
            r_index  <= '0;
            r_hcount <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FORM:   r_form   <= i_cfg_data[1:0];
                CFG_AMP:    r_amp    <= i_cfg_data[15:0];
                CFG_CPITCH: r_cpitch <= i_cfg_data;
                CFG_MPITCH: r_mpitch <= i_cfg_data;
                CFG_INDEX:  r_index  <= i_cfg_data[15:0];
                CFG_HCOUNT: r_hcount <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.env_wr) begin
            r_env_mem[i_in.env_addr] <= i_in.env_value;
        end
        if (i_cmd.rd_mod) begin
            r_env_q <= r_env_mem[r_pos];
        end
    end

    always_comb begin
        if (i_cmd.rd_car) begin
            ph_sel = r_c;
        end else if (i_cmd.harm_issue) begin
            ph_sel = r_hp;
        end else begin
            ph_sel = r_mp;
        end
        rom_idx = ph_sel[PH_W-1:PHASE_FRACTION_BITS];
        rom_ext = {1'b0, rom_idx[TBL_BITS-2:0]};
        rom_j   = (rom_ext <= TBL_BITS'(TBL_QUARTER)) ? rom_ext
                : TBL_BITS'(TBL_HALF) - rom_ext;
        qidx    = rom_j[QIDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_rq   <= SINE_Q[qidx];
        r_rneg <= rom_idx[TBL_BITS-1];
    end

    assign mag16    = {1'b0, r_rq};
    assign sine_val = r_rneg ? -$signed(mag16) : $signed(mag16);

    assign pmag    = r_p[48] ? 49'(-r_p) : 49'(r_p);
    assign offprod = pmag[48:21] * INV_TWO_PI_Q32;
    assign off64   = (64'(r_offa) << OFF_LSH) >> OFF_RSH;
    assign offp    = off64[PH_W-1:0];
    assign base    = (r_form == FORM_SAW) ? PH_W'(0) - r_c : r_c;

    assign hc8 = {1'b0, r_hcount};
    assign h   = (hc8 > 8'(MAX_HARMONICS)) ? K_W'(MAX_HARMONICS) : K_W'(hc8);
    assign hq  = r_prod[54:31];

    assign smag  = r_sum[31] ? 32'(-r_sum) : 32'(r_sum);
    assign gsel  = (r_form == FORM_SAW) ? SAW_GAIN_Q16 : SQ_GAIN_Q16;
    assign gprod = smag * gsel;
    assign gq    = gprod[48:24];
    assign amag  = r_s[25] ? 26'(-r_s) : 26'(r_s);
    assign aprod = amag * r_amp;
    assign aq    = aprod[41:15];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_ei <= r_env_q * $signed({1'b0, r_index});
            r_m  <= sine_val;
        end
        if (i_cmd.mul2) begin
            r_p <= r_ei * r_m;
        end
        if (i_cmd.off1) begin
            r_offa <= offprod[57:24];
            r_pneg <= r_p[48];
        end
        if (i_cmd.off2) begin
            r_c <= r_pneg ? r_cp - offp : r_cp + offp;
        end
        if (i_cmd.harm_init) begin
            r_hp  <= base;
            r_inc <= (r_form == FORM_SAW) ? base : PH_W'({base, 1'b0});
            r_k   <= K_W'(1);
        end else if (i_cmd.harm_issue) begin
            r_hp <= r_hp + r_inc;
            r_k  <= r_k + ((r_form == FORM_SAW) ? K_W'(1) : K_W'(2));
        end
        r_k1   <= r_k;
        r_prod <= {r_rq, 8'd0} * RECIP[r_k1];
        r_pn   <= r_rneg;
        if (i_cmd.harm_init) begin
            r_sum <= '0;
        end else if (r_v2) begin
            r_sum <= r_pn ? r_sum - $signed(32'(hq)) : r_sum + $signed(32'(hq));
        end
        if (i_cmd.sine_cap) begin
            r_s <= 26'(sine_val);
        end else if (i_cmd.s_zero) begin
            r_s <= '0;
        end else if (i_cmd.gain) begin
            r_s <= r_sum[31] ? -$signed({1'b0, gq}) : $signed({1'b0, gq});
        end
        if (i_cmd.scale) begin
            r_y <= r_s[25] ? -$signed({1'b0, aq}) : $signed({1'b0, aq});
        end
        if (i_cmd.out_load) begin
            if (r_y > 28'sd32767) begin
                o_out.sample_out <= 16'sh7fff;
                o_out.clipped    <= 1'b1;
            end else if (r_y < -28'sd32768) begin
                o_out.sample_out <= 16'sh8000;
                o_out.clipped    <= 1'b1;
            end else begin
                o_out.sample_out <= r_y[15:0];
                o_out.clipped    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp        <= '0;
            r_mp        <= '0;
            r_pos       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.harm_issue;
            r_v2 <= r_v1;
            if (i_cmd.out_load) begin
                r_cp        <= r_cp + PH_W'(r_cpitch);
                r_mp        <= r_mp + PH_W'(r_mpitch);
                r_pos       <= r_pos + 1'b1;
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.form      = r_form;
    assign o_sts.harm_done = (r_k > h);
    assign o_sts.pipe_busy = r_v1 || r_v2;
    assign o_sts.out_busy  = o_out_valid && !i_out_ready;

endmodule

[verif/testbench.sv]
// Self-checking testbench for the two-operator FM voice with a bit-exact predictor.
`timescale 1ns / 1ps
module testbench;
    import fmv_pkg::*;

    localparam longint SAW_GAIN    = 41722;
    localparam longint SQUARE_GAIN = 83443;
    localparam int     SETTLE      = 80;
    localparam int     ENV_LOADED  = 448;

    typedef struct {
        bit        is_cfg;
        logic [2:0]  cfg_idx;
        logic [27:0] cfg_data;
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [27:0] i_cfg_data;

    int          sine_table [TABLE_SIZE];
    logic signed [15:0] env_mem [ENV_DEPTH];
    logic [1:0]  form_q;
    logic [15:0] amp_q;
    logic [27:0] cpitch_q;
    logic [27:0] mpitch_q;
    logic [15:0] index_q;
    logic [6:0]  hcount_q;
    logic [27:0] car_phase;
    logic [27:0] mod_phase;
    logic [11:0] env_pos;

    t_out_item   pending_samples [$];
    t_row        directed_rows [$];
    int          error_count;
    int          samples_seen;
    int          hold_left;
    int          stall_left;
    bit          quiet;

    fm_voice_oscillator_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int quarter_wave(longint unsigned j);
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        x    = (j * 64'd6746518852) / TABLE_SIZE;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return int'((longint'(acc) * 32767 + (64'd1 << 29)) >>> 30);
    endfunction

    function automatic void fill_sine_table();
        int r;
        int j;
        int v;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            r = (i < TABLE_SIZE / 2) ? i : i - TABLE_SIZE / 2;
            j = (r <= TABLE_SIZE / 4) ? r : TABLE_SIZE / 2 - r;
            v = quarter_wave(j);
            sine_table[i] = (i < TABLE_SIZE / 2) ? v : -v;
        end
    endfunction

    function automatic longint sine_at(logic [27:0] ph);
        return longint'(sine_table[ph[27:16]]);
    endfunction

    function automatic longint shift_toward_zero(longint v, int n);
        return (v < 0) ? -((-v) >> n) : (v >> n);
    endfunction

    function automatic longint harmonic_sum(logic [27:0] ph, int h, int step);
        longint          acc;
        longint unsigned prod;
        acc = 0;
        for (int k = 1; k <= h; k += step) begin
            prod = longint'(k) * longint'(ph);
            acc  = acc + (sine_at(prod[27:0]) * 256) / longint'(k);
        end
        return acc;
    endfunction

    function automatic t_out_item predict_sample();
        t_out_item       res;
        longint          e;
        longint          m;
        longint          p;
        longint          s;
        longint          y;
        longint unsigned mag;
        logic [27:0]     c;
        int              h;
        e   = longint'(env_mem[env_pos]);
        m   = sine_at(mod_phase);
        p   = e * longint'(index_q) * m;
        mag = (p < 0) ? -p : p;
        mag = (((mag >> 21) * 64'd683565276) >> 24) * TABLE_SIZE;
        mag = mag >> (24 - PHASE_FRACTION_BITS);
        c   = (p < 0) ? car_phase - mag[27:0] : car_phase + mag[27:0];
        h   = (hcount_q > MAX_HARMONICS) ? MAX_HARMONICS : int'(hcount_q);
        case (form_q)
            FORM_SINE: s = sine_at(c);
            FORM_SAW: s = shift_toward_zero(harmonic_sum(-c, h, 1) * SAW_GAIN, 24);
            FORM_SQUARE: s = shift_toward_zero(harmonic_sum(c, h, 2) * SQUARE_GAIN, 24);
            default: s = 0;
        endcase
        y = shift_toward_zero(s * longint'(amp_q), 15);
        res.clipped = 1'b0;
        if (y > 32767) begin
            y = 32767;
            res.clipped = 1'b1;
        end
        if (y < -32768) begin
            y = -32768;
            res.clipped = 1'b1;
        end
        res.sample_out = y[15:0];
        car_phase = car_phase + cpitch_q;
        mod_phase = mod_phase + mpitch_q;
        env_pos   = env_pos + 12'd1;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [27:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            CFG_FORM:   form_q   = data[1:0];
            CFG_AMP:    amp_q    = data[15:0];
            CFG_CPITCH: cpitch_q = data;
            CFG_MPITCH: mpitch_q = data;
            CFG_INDEX:  index_q  = data[15:0];
            CFG_HCOUNT: hcount_q = data[6:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_item(t_in_item item, bit typed, t_out_item want);
        t_out_item got;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        if (item.cmd == CMD_WRITE) begin
            env_mem[item.env_addr] = item.env_value;
        end else begin
            got = predict_sample();
            pending_samples.push_back(typed ? want : got);
        end
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        t_in_item it;
        it = '{cmd: CMD_TICK, env_addr: 12'($urandom), env_value: 16'($urandom)};
        send_item(it, 1'b0, '0);
    endtask

    task automatic send_write(logic [11:0] addr, logic [15:0] val);
        send_item('{cmd: CMD_WRITE, env_addr: addr, env_value: val}, 1'b0, '0);
    endtask

    function automatic logic [27:0] pick_pitch();
        case ($urandom_range(0, 4))
            0: return 28'd0;
            1: return 28'h8000000;
            2: return 28'hFFFFFFF;
            3: return 28'($urandom_range(0, 32'h0400000));
            default: return 28'($urandom);
        endcase
    endfunction

    function automatic void push_cfg(logic [2:0] idx, logic [27:0] data);
        t_row r;
        r = '{is_cfg: 1'b1, cfg_idx: idx, cfg_data: data, item: '0, typed: 1'b0, want: '0};
        directed_rows.push_back(r);
    endfunction

    function automatic void push_item(t_in_item it, bit typed, t_out_item want);
        t_row r;
        r = '{is_cfg: 1'b0, cfg_idx: '0, cfg_data: '0, item: it, typed: typed, want: want};
        directed_rows.push_back(r);
    endfunction

    function automatic void build_directed_rows();
        t_in_item tick;
        tick = '{cmd: CMD_TICK, env_addr: 12'hFFF, env_value: 16'sh7FFF};
        push_item(tick, 1'b1, '{sample_out: 16'sd0, clipped: 1'b0});
        push_cfg(CFG_FORM, 28'd3);
        push_item(tick, 1'b1, '{sample_out: 16'sd0, clipped: 1'b0});
        push_cfg(CFG_FORM, 28'(FORM_SINE));
        push_cfg(CFG_CPITCH, 28'h8000000);
        push_cfg(CFG_MPITCH, 28'hFFFFFFF);
        push_cfg(CFG_INDEX, 28'hFFFF);
        push_item('{cmd: CMD_WRITE, env_addr: 12'd2, env_value: 16'sh8000}, 1'b0, '0);
        push_item('{cmd: CMD_WRITE, env_addr: 12'd3, env_value: 16'sh7FFF}, 1'b0, '0);
        push_item(tick, 1'b0, '0);
        push_item(tick, 1'b0, '0);
        push_cfg(CFG_AMP, 28'd0);
        push_item(tick, 1'b1, '{sample_out: 16'sd0, clipped: 1'b0});
        push_cfg(CFG_AMP, 28'hFFFF);
        push_cfg(CFG_FORM, 28'(FORM_SAW));
        push_cfg(CFG_HCOUNT, 28'd0);
        push_item(tick, 1'b1, '{sample_out: 16'sd0, clipped: 1'b0});
        push_cfg(CFG_HCOUNT, 28'd127);
        push_item(tick, 1'b0, '0);
        push_cfg(CFG_FORM, 28'(FORM_SQUARE));
        push_item(tick, 1'b0, '0);
        push_cfg(CFG_HCOUNT, 28'd64);
        push_cfg(CFG_AMP, 28'd32768);
        push_item(tick, 1'b0, '0);
        push_cfg(CFG_FORM, 28'(FORM_SAW));
        push_item(tick, 1'b0, '0);
    endfunction

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 15);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            samples_seen++;
            if (samples_seen == 150) begin
                hold_left = 400;
            end
            if (pending_samples.size() == 0) begin
                report_mismatch("unexpected sample", o_out.sample_out, 0);
            end else begin
                want = pending_samples.pop_front();
                if (o_out.sample_out !== want.sample_out) begin
                    report_mismatch("sample_out", o_out.sample_out, want.sample_out);
                end
                if (o_out.clipped !== want.clipped) begin
                    report_mismatch("clipped", o_out.clipped, want.clipped);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_out_ready = 1'b0;
        error_count = 0;
        samples_seen = 0;
        hold_left   = 0;
        stall_left  = 0;
        quiet       = 1'b0;
        form_q   = FORM_SINE;
        amp_q    = 16'd32768;
        cpitch_q = '0;
        mpitch_q = '0;
        index_q  = '0;
        hcount_q = '0;
        car_phase = '0;
        mod_phase = '0;
        env_pos   = '0;
        fill_sine_table();
        build_directed_rows();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The envelope is loaded well past the last position any tick reaches,
        // so no tick ever reads an unwritten entry.
        for (int a = 0; a < ENV_LOADED; a++) begin
            if (a == 0) begin
                send_write(12'(a), 16'h8000);
            end else if (a == ENV_LOADED - 1) begin
                send_write(12'(a), 16'h7FFF);
            end else begin
                send_write(12'(a), 16'($urandom));
            end
        end

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                wait_idle();
                write_register(directed_rows[i].cfg_idx, directed_rows[i].cfg_data);
            end else begin
                send_item(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].want);
            end
        end

        for (int ph = 0; ph < 9; ph++) begin
            wait_idle();
            quiet = (ph == 8);
            write_register(CFG_FORM, 28'($urandom_range(0, 3)));
            case ($urandom_range(0, 3))
                0: write_register(CFG_AMP, 28'd0);
                1: write_register(CFG_AMP, 28'd32768);
                2: write_register(CFG_AMP, 28'hFFFF);
                default: write_register(CFG_AMP, 28'($urandom_range(0, 16'hFFFF)));
            endcase
            write_register(CFG_CPITCH, pick_pitch());
            write_register(CFG_MPITCH, pick_pitch());
            case ($urandom_range(0, 2))
                0: write_register(CFG_INDEX, 28'hFFFF);
                1: write_register(CFG_INDEX, 28'($urandom_range(0, 16'h0FFF)));
                default: write_register(CFG_INDEX, 28'($urandom_range(0, 16'hFFFF)));
            endcase
            case ($urandom_range(0, 4))
                0: write_register(CFG_HCOUNT, 28'd0);
                1: write_register(CFG_HCOUNT, 28'd1);
                2: write_register(CFG_HCOUNT, 28'd64);
                3: write_register(CFG_HCOUNT, 28'd127);
                default: write_register(CFG_HCOUNT, 28'($urandom_range(0, 127)));
            endcase
            for (int n = 0; n < 44; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_write(12'($urandom), 16'($urandom));
                end else begin
                    send_tick();
                end
            end
        end

        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[fm_voice_oscillator_top.f]
rtl/core/fmv_pkg.sv
rtl/core/fmv_ctrl.sv
rtl/core/fmv_dp.sv
rtl/core/fm_voice_oscillator_top.sv
verif/testbench.sv
